FILE: sv/dzr_pkg.sv
// Shared constants, types and control structs for the diagonal zigzag reorder block.
package dzr_pkg;

  // Matrix bounds and derived widths
  localparam int MAX_ROWS  = 8;
  localparam int MAX_COLS  = 8;
  localparam int DEPTH     = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W   = $clog2(DEPTH + 1);
  localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DIMR_W    = $clog2(MAX_ROWS + 1);
  localparam int DIMC_W    = $clog2(MAX_COLS + 1);
  localparam int DIAG_W    = $clog2(MAX_ROWS + MAX_COLS);
  localparam int SUM_W     = ROW_W + DIMC_W + 1;

  // Field and register widths
  localparam int DATA_W    = 32;
  localparam int DIM_W     = 4;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = CFG_IDX_W'(1);

  // Reset value of both dimension registers
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

  // Controller states
  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // write element, bump load count
    logic finish;  // matrix complete: clear count, start scan at origin
    logic step;    // read current scan position, advance
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic load_last;  // the element being loaded completes the matrix
    logic at_end;     // scan position is the bottom-right element
  } sts_t;

endpackage

FILE: sv/dzr_ctrl.sv
// Controller: load/emit sequencing and the output valid flag.
module dzr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  dzr_pkg::sts_t sts,
  output dzr_pkg::cmd_t cmd
);
  import dzr_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  // Next state and commands
  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.load_last) begin
            cmd.finish = 1'b1;
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        // issue a read whenever the output register is free or draining
        if (!out_valid || out_ready) begin
          cmd.step = 1'b1;
          if (sts.at_end) state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Output valid follows reads and transfers
  always_comb begin
    if (cmd.step) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // A read never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (!out_valid || out_ready))
    else $error("read issued while output register is occupied");

  // The final read of a matrix hands control back to loading
  a_end_to_load: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && sts.at_end) |=> (state == ST_LOAD))
    else $error("scan did not return to load after last element");

  // A completing transfer starts emission and drops in_ready
  a_finish_emit: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && sts.load_last) |=> (state == ST_EMIT && !in_ready))
    else $error("completing element did not start emission");

endmodule

FILE: sv/dzr_datapath.sv
// Datapath: config registers, element store, load counter and zigzag scan position.
module dzr_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dzr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dzr_pkg::DIM_W-1:0]         cfg_data,
  input  logic signed [dzr_pkg::DATA_W-1:0] element_value,
  output logic signed [dzr_pkg::DATA_W-1:0] out_value,
  output logic                              out_last,
  input  dzr_pkg::cmd_t                     cmd,
  output dzr_pkg::sts_t                     sts
);
  import dzr_pkg::*;

  logic [DIM_W-1:0]   row_count, col_count;
  logic [DIMR_W-1:0]  rows;
  logic [DIMC_W-1:0]  cols;
  logic [COUNT_W-1:0] total;
  logic [COUNT_W-1:0] load_count, load_count_inc;
  logic [ROW_W-1:0]   row, row_next;
  logic [COL_W-1:0]   col, col_next;
  logic [DIAG_W-1:0]  diag_inc, row_last_d, col_last_d, start_r, start_c;
  logic [SUM_W-1:0]   rd_sum;
  logic [ADDR_W-1:0]  rd_addr;
  logic               diag_odd, can_up_right, can_down_left;

  logic [DATA_W-1:0]  element_store [DEPTH];

  assign cfg_ready = 1'b1;

  // Configuration registers keep the written bits
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= DIM_RESET;
      col_count <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_ROW_COUNT) row_count <= cfg_data;
      if (cfg_index == CFG_COL_COUNT) col_count <= cfg_data;
    end
  end

  // Effective dimensions clamped to 1..MAX
  always_comb begin
    if (row_count == '0) rows = DIMR_W'(1);
    else if (int'(row_count) > MAX_ROWS) rows = DIMR_W'(MAX_ROWS);
    else rows = DIMR_W'(row_count);
    if (col_count == '0) cols = DIMC_W'(1);
    else if (int'(col_count) > MAX_COLS) cols = DIMC_W'(MAX_COLS);
    else cols = DIMC_W'(col_count);
  end

  assign total          = COUNT_W'(rows) * COUNT_W'(cols);
  assign load_count_inc = load_count + COUNT_W'(1);
  assign sts.load_last  = (load_count_inc >= total);

  // Load counter
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (cmd.load) begin
      load_count <= cmd.finish ? '0 : load_count_inc;
    end
  end

  // Next position along the zigzag
  assign diag_odd      = row[0] ^ col[0];
  assign diag_inc      = DIAG_W'(row) + DIAG_W'(col) + DIAG_W'(1);
  assign row_last_d    = DIAG_W'(rows) - DIAG_W'(1);
  assign col_last_d    = DIAG_W'(cols) - DIAG_W'(1);
  assign can_up_right  = (row != '0) && (DIAG_W'(col) < col_last_d);
  assign can_down_left = (col != '0) && (DIAG_W'(row) < row_last_d);
  assign sts.at_end    = (DIAG_W'(row) == row_last_d) && (DIAG_W'(col) == col_last_d);

  always_comb begin
    start_r  = '0;
    start_c  = '0;
    row_next = row;
    col_next = col;
    if (diag_odd) begin
      // down-left; next diagonal goes up-right from row min(d, rows-1)
      start_r = (diag_inc < row_last_d) ? diag_inc : row_last_d;
      start_c = diag_inc - start_r;
      if (can_down_left) begin
        row_next = row + ROW_W'(1);
        col_next = col - COL_W'(1);
      end else begin
        row_next = ROW_W'(start_r);
        col_next = COL_W'(start_c);
      end
    end else begin
      // up-right; next diagonal goes down-left from column min(d, cols-1)
      start_c = (diag_inc < col_last_d) ? diag_inc : col_last_d;
      start_r = diag_inc - start_c;
      if (can_up_right) begin
        row_next = row - ROW_W'(1);
        col_next = col + COL_W'(1);
      end else begin
        row_next = ROW_W'(start_r);
        col_next = COL_W'(start_c);
      end
    end
  end

  // Scan position
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (cmd.finish) begin
      row <= '0;
      col <= '0;
    end else if (cmd.step) begin
      row <= row_next;
      col <= col_next;
    end
  end

  // Store address of the current position, row-major
  assign rd_sum  = SUM_W'(row) * SUM_W'(cols) + SUM_W'(col);
  assign rd_addr = rd_sum[ADDR_W-1:0];

  // Element store: one write port, registered read into the output register
  always_ff @(posedge clk) begin
    if (cmd.load) element_store[load_count[ADDR_W-1:0]] <= element_value;
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_value <= element_store[rd_addr];
      out_last  <= sts.at_end;
    end
  end

  // A completed matrix restarts the scan and the count from zero
  a_finish_origin: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (row == '0 && col == '0 && load_count == '0))
    else $error("scan or count not cleared after matrix completion");

endmodule

FILE: sv/diagonal_zigzag_reorder.sv
// Loading: in_ready stays high; the completing element starts emission, whose reads fill the
// output register. Emission runs one element per cycle while out_ready is high; in_ready is
// low meanwhile. A whole matrix is loaded before it is read out, but the output register lets
// loading of the next matrix start while the last result waits. Emission reads only addresses
// loaded for its matrix unless the dimensions change during emission. Reset (rst, synchronous):
// load count and scan clear, dimensions return to 8x8; store contents are not cleared.
module diagonal_zigzag_reorder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [dzr_pkg::DATA_W-1:0] element_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [dzr_pkg::DATA_W-1:0] out_value,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dzr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dzr_pkg::DIM_W-1:0]         cfg_data
);
  import dzr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing
  dzr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage and addressing
  dzr_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .element_value (element_value),
    .out_value     (out_value),
    .out_last      (out_last),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

FILE: tb/diagonal_zigzag_reorder_tb.sv
// Self-checking testbench for the diagonal zigzag reorder block.
`timescale 1ns / 1ps

module diagonal_zigzag_reorder_tb;
  import dzr_pkg::*;

  localparam int ITEM_TARGET = 320;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } zz_result_t;

  // DUT ports
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] element_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_last;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DIM_W-1:0]         cfg_data = '0;

  // Predictor state
  logic [DATA_W-1:0] matrix_mem [DEPTH];
  int                loaded_cnt;
  logic [DIM_W-1:0]  rows_cfg;
  logic [DIM_W-1:0]  cols_cfg;
  zz_result_t        zigzag_q [$];
  zz_result_t        head;

  // Run bookkeeping
  int err_cnt = 0;
  int sent_cnt = 0;
  int stall_cycles = 0;

  // Sender and receiver pacing
  bit rx_throttle = 1'b0;
  bit tx_throttle = 1'b0;
  int rx_hold_req = 0;
  int rx_hold_left = 0;
  int rx_gap = 0;

  diagonal_zigzag_reorder dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .element_value (element_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < DEPTH; i++) matrix_mem[i] = '0;
    loaded_cnt = 0;
    rows_cfg = DIM_RESET;
    cols_cfg = DIM_RESET;
  endfunction

  // Store one element; on the completing one, queue the whole matrix in zigzag order
  function automatic void predict_zigzag(input logic [DATA_W-1:0] v);
    int rows, cols, total, lo, hi, r, c;
    zz_result_t res;
    rows = clamp_dim(rows_cfg, MAX_ROWS);
    cols = clamp_dim(cols_cfg, MAX_COLS);
    total = rows * cols;
    sent_cnt++;
    if (loaded_cnt < DEPTH) matrix_mem[loaded_cnt] = v;
    loaded_cnt = (loaded_cnt + 1) & 8'h7F;
    if (loaded_cnt < total) return;
    for (int d = 0; d + 1 < rows + cols; d++) begin
      if (d % 2 == 1) begin
        // down-left: row ascends
        lo = (d + 1 > cols) ? d + 1 - cols : 0;
        hi = (d + 1 < rows) ? d + 1 : rows;
      end else begin
        // up-right: column ascends
        lo = (d + 1 > rows) ? d + 1 - rows : 0;
        hi = (d + 1 < cols) ? d + 1 : cols;
      end
      for (int i = lo; i < hi; i++) begin
        r = (d % 2 == 1) ? i : d - i;
        c = (d % 2 == 1) ? d - i : i;
        res.value = matrix_mem[(r * cols + c) % DEPTH];
        res.last  = 1'b0;
        zigzag_q.insert(zigzag_q.size(), res);
      end
    end
    zigzag_q[$].last = 1'b1;
    loaded_cnt = 0;
  endfunction

  function automatic logic [DATA_W-1:0] random_element();
    case ($urandom_range(0, 19))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // One element transfer, with an optional gap in front of it
  task automatic send_element(input logic [DATA_W-1:0] v);
    int gap;
    gap = 0;
    if (tx_throttle && $urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    element_value <= v;
    do @(posedge clk); while (!in_ready);
    predict_zigzag(v);
  endtask

  // Random elements until the current matrix completes
  task automatic send_matrix();
    do send_element(random_element()); while (loaded_cnt != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_ROW_COUNT) rows_cfg = val;
    else if (idx == CFG_COL_COUNT) cols_cfg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, wait for all queued results, then let a load in flight settle
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (zigzag_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Reset dimensions (8x8) while the receiver holds off for a long stretch
  task automatic test_default_backpressure();
    tx_throttle = 1'b0;
    rx_throttle = 1'b0;
    rx_hold_req = HOLD_CYCLES;
    send_matrix();
    send_matrix();
    quiesce();
  endtask

  // 1x1 matrix: every element comes straight back, marked last
  task automatic test_single_element();
    write_reg(CFG_ROW_COUNT, DIM_W'(1));
    write_reg(CFG_COL_COUNT, DIM_W'(1));
    send_element(32'h8000_0000);
    send_element(32'h7FFF_FFFF);
    send_element(32'h0000_0000);
    send_element(32'hFFFF_FFFF);
    send_element(32'h0000_0001);
    quiesce();
  endtask

  // Zero and oversized dimensions clamp to 1 and to the maximum
  task automatic test_dim_clamp();
    write_reg(CFG_ROW_COUNT, DIM_W'(0));
    write_reg(CFG_COL_COUNT, DIM_W'(3));
    send_matrix();
    quiesce();
    write_reg(CFG_ROW_COUNT, DIM_W'(15));
    write_reg(CFG_COL_COUNT, DIM_W'(0));
    send_matrix();
    quiesce();
  endtask

  // Writes to indexes past the register list leave the dimensions alone
  task automatic test_ignored_index();
    write_reg(CFG_ROW_COUNT, DIM_W'(2));
    write_reg(CFG_COL_COUNT, DIM_W'(3));
    write_reg(CFG_IDX_W'(2), DIM_W'(15));
    write_reg(CFG_IDX_W'(3), DIM_W'(1));
    send_matrix();
    quiesce();
  endtask

  // Dimensions change with a partial matrix loaded: shrink below, then grow above
  task automatic test_resize_mid_matrix();
    write_reg(CFG_ROW_COUNT, DIM_W'(3));
    write_reg(CFG_COL_COUNT, DIM_W'(3));
    repeat (5) send_element(random_element());
    quiesce();
    write_reg(CFG_ROW_COUNT, DIM_W'(2));
    write_reg(CFG_COL_COUNT, DIM_W'(2));
    send_element(random_element());
    quiesce();
    repeat (2) send_element(random_element());
    quiesce();
    write_reg(CFG_ROW_COUNT, DIM_W'(3));
    send_matrix();
    quiesce();
  endtask

  // Random shapes and contents, some with a resize partway through
  task automatic test_random_matrices();
    while (sent_cnt < ITEM_TARGET) begin
      tx_throttle = ($urandom_range(0, 3) != 0);
      rx_throttle = ($urandom_range(0, 3) != 0);
      write_reg(CFG_ROW_COUNT, DIM_W'($urandom_range(0, 15)));
      write_reg(CFG_COL_COUNT, DIM_W'($urandom_range(0, 15)));
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 20)) send_element(random_element());
        quiesce();
        write_reg(CFG_IDX_W'($urandom_range(0, 3)), DIM_W'($urandom_range(0, 15)));
      end
      send_matrix();
      quiesce();
    end
  endtask

  // Receiver: long hold when requested, otherwise random short and long gaps
  always @(negedge clk) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left--;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap--;
    end else if (rx_throttle && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      rx_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest queued expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (zigzag_q.size() == 0) begin
        $display("%0t: unexpected result, value %h last %b", $time, out_value, out_last);
        err_cnt++;
      end else begin
        head = zigzag_q.pop_front();
        if (out_value !== head.value) begin
          $display("%0t: out_value expected %h actual %h", $time, head.value, out_value);
          err_cnt++;
        end
        if (out_last !== head.last) begin
          $display("%0t: out_last expected %b actual %b", $time, head.last, out_last);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: too many cycles without any transfer ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    reset_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_backpressure();
    test_single_element();
    test_dim_clamp();
    test_ignored_index();
    test_resize_mid_matrix();
    test_random_matrices();
    quiesce();
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && zigzag_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
